[hdl/mpc_pkg.sv]
// shared types and constants for the masked paillier pixel cipher
package mpc_pkg;

  // field and register widths
  localparam int SAMPLE_W   = 62;
  localparam int MOD_W      = 31;
  localparam int SIDE_W     = 13;
  localparam int BYTE_W     = 8;
  localparam int MN_W       = MOD_W + BYTE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // default frame limit
  localparam int MAX_SIDE_DEFAULT = 4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_N    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

  // register reset values
  localparam logic [MOD_W-1:0]  RST_MODULUS_N    = 31'd3233;
  localparam logic              RST_CIPHER_MODE  = 1'b0;
  localparam logic [SIDE_W-1:0] RST_FRAME_WIDTH  = 13'd128;
  localparam logic [SIDE_W-1:0] RST_FRAME_HEIGHT = 13'd128;

  // cipher modes
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // result source codes
  localparam int RES_SEL_W = 2;
  localparam logic [RES_SEL_W-1:0] RES_PASS = 2'd0;
  localparam logic [RES_SEL_W-1:0] RES_ZERO = 2'd1;
  localparam logic [RES_SEL_W-1:0] RES_REM  = 2'd2;
  localparam logic [RES_SEL_W-1:0] RES_QUO  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic                 load;
    logic                 prep;
    logic                 div_start;
    logic                 div_second;
    logic                 out_load;
    logic [RES_SEL_W-1:0] res_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic selected;
    logic n_zero;
    logic c_zero;
    logic decrypt;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

[hdl/mpc_divider.sv]
// restoring divider, one quotient bit per cycle
module mpc_divider #(
  parameter int WIDTH = mpc_pkg::SAMPLE_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [CNT_W-1:0] count;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;

  assign trial = {rem, quo[WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(WIDTH);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo <= {quo[WIDTH-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

[hdl/mpc_datapath.sv]
// position counters, products, divider and output register
module mpc_datapath #(
  parameter int MAX_SIDE = mpc_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mpc_pkg::cmd_t                 cmd,
  output mpc_pkg::stat_t                stat,
  input  logic [mpc_pkg::MOD_W-1:0]     modulus_n,
  input  logic                          cipher_mode,
  input  logic [mpc_pkg::SIDE_W-1:0]    frame_width,
  input  logic [mpc_pkg::SIDE_W-1:0]    frame_height,
  input  logic [mpc_pkg::SAMPLE_W-1:0]  sample_value,
  output logic [mpc_pkg::SAMPLE_W-1:0]  result_value,
  output logic                          was_transformed,
  output logic                          frame_last,
  output logic                          out_valid,
  input  logic                          out_ready
);

  localparam int CW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CMPW = ((CW > mpc_pkg::SIDE_W) ? CW : mpc_pkg::SIDE_W) + 1;
  localparam int SW   = mpc_pkg::SAMPLE_W;

  logic [CW-1:0]            column_index;
  logic [CW-1:0]            row_index;
  logic [CMPW-1:0]          w_ext, h_ext, w_side, h_side;
  logic [CMPW-1:0]          col_ext, row_ext, col_inc, row_inc, pos_sum;
  logic                     row_end, frame_end, selected_now;

  logic [SW-1:0]            sample;
  logic                     sel_q;
  logic                     last_q;
  logic [SW-1:0]            prod_nsq;
  logic [mpc_pkg::MN_W-1:0] prod_mn;
  logic [SW-1:0]            nsq_full;
  logic [mpc_pkg::MN_W-1:0] mn_full;

  logic [SW-1:0]            div_dividend, div_divisor, div_quo, div_rem;
  logic                     div_busy, div_done;
  logic [SW-1:0]            res_next;
  logic                     out_free;

  // clamp the frame sides into one..MAX_SIDE
  assign w_ext  = CMPW'(frame_width);
  assign h_ext  = CMPW'(frame_height);
  assign w_side = (w_ext == '0) ? CMPW'(1) :
                  (w_ext > CMPW'(MAX_SIDE)) ? CMPW'(MAX_SIDE) : w_ext;
  assign h_side = (h_ext == '0) ? CMPW'(1) :
                  (h_ext > CMPW'(MAX_SIDE)) ? CMPW'(MAX_SIDE) : h_ext;

  assign col_ext      = CMPW'(column_index);
  assign row_ext      = CMPW'(row_index);
  assign col_inc      = col_ext + CMPW'(1);
  assign row_inc      = row_ext + CMPW'(1);
  assign pos_sum      = col_ext + row_ext;
  assign selected_now = (pos_sum[1:0] == 2'b00);
  assign row_end      = (col_inc >= w_side);
  assign frame_end    = row_end && (row_inc >= h_side);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
    end else if (cmd.load) begin
      if (row_end) begin
        column_index <= '0;
        row_index    <= (row_inc >= h_side) ? '0 : row_inc[CW-1:0];
      end else begin
        column_index <= col_inc[CW-1:0];
      end
    end
  end

  // item capture and products
  assign nsq_full = SW'(modulus_n) * SW'(modulus_n);
  assign mn_full  = mpc_pkg::MN_W'(sample[mpc_pkg::BYTE_W-1:0]) * mpc_pkg::MN_W'(modulus_n);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= sample_value;
      sel_q  <= selected_now;
      last_q <= frame_end;
    end
    if (cmd.prep) begin
      prod_nsq <= nsq_full;
      prod_mn  <= mn_full;
    end
  end

  // first pass reduces mod n squared, second pass divides by n
  always_comb begin
    if (cmd.div_second) begin
      div_dividend = div_rem;
      div_divisor  = SW'(modulus_n);
    end else begin
      div_divisor = prod_nsq;
      if (cipher_mode == mpc_pkg::MODE_DECRYPT) begin
        div_dividend = sample - SW'(1);
      end else begin
        div_dividend = SW'(prod_mn) + SW'(1);
      end
    end
  end

  mpc_divider #(
    .WIDTH (SW)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    case (cmd.res_sel)
      mpc_pkg::RES_PASS: res_next = sample;
      mpc_pkg::RES_ZERO: res_next = '0;
      mpc_pkg::RES_REM:  res_next = div_rem;
      mpc_pkg::RES_QUO:  res_next = div_quo;
      default:           res_next = '0;
    endcase
  end

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_value    <= res_next;
      was_transformed <= sel_q;
      frame_last      <= last_q;
    end
  end

  assign stat.selected = sel_q;
  assign stat.n_zero   = (modulus_n == '0);
  assign stat.c_zero   = (sample == '0);
  assign stat.decrypt  = (cipher_mode == mpc_pkg::MODE_DECRYPT);
  assign stat.div_done = div_done;
  assign stat.out_free = out_free;

  a_out_free: assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> out_free)
    else $error("output register overwritten");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
      (col_ext < CMPW'(MAX_SIDE)) && (row_ext < CMPW'(MAX_SIDE)))
    else $error("position counter out of range");
  a_div_idle: assert property (@(posedge clk) disable iff (rst) cmd.div_start |-> !div_busy)
    else $error("divider pass requested while busy");

endmodule

[hdl/mpc_ctrl.sv]
// controller state machine for the pixel cipher
module mpc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mpc_pkg::stat_t stat,
  output mpc_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_WAIT1 = 3'd3;
  localparam logic [2:0] S_DIV2  = 3'd4;
  localparam logic [2:0] S_WAIT2 = 3'd5;
  localparam logic [2:0] S_WRITE = 3'd6;

  logic [2:0]                     state, state_next;
  logic [mpc_pkg::RES_SEL_W-1:0]  res_sel, res_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      res_sel <= mpc_pkg::RES_PASS;
    end else begin
      state   <= state_next;
      res_sel <= res_sel_next;
    end
  end

  always_comb begin
    state_next     = state;
    res_sel_next   = res_sel;
    cmd.load       = 1'b0;
    cmd.prep       = 1'b0;
    cmd.div_start  = 1'b0;
    cmd.div_second = 1'b0;
    cmd.out_load   = 1'b0;
    cmd.res_sel    = res_sel;
    in_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        // no transfer while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (!stat.selected) begin
          res_sel_next = mpc_pkg::RES_PASS;
          state_next   = S_WRITE;
        end else if (stat.n_zero || (stat.decrypt && stat.c_zero)) begin
          res_sel_next = mpc_pkg::RES_ZERO;
          state_next   = S_WRITE;
        end else begin
          state_next = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT1;
      end
      S_WAIT1: begin
        if (stat.div_done) begin
          if (stat.decrypt) begin
            state_next = S_DIV2;
          end else begin
            res_sel_next = mpc_pkg::RES_REM;
            state_next   = S_WRITE;
          end
        end
      end
      S_DIV2: begin
        cmd.div_start  = 1'b1;
        cmd.div_second = 1'b1;
        state_next     = S_WAIT2;
      end
      S_WAIT2: begin
        cmd.div_second = 1'b1;
        if (stat.div_done) begin
          res_sel_next = mpc_pkg::RES_QUO;
          state_next   = S_WRITE;
        end
      end
      S_WRITE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/masked_paillier_pixel_cipher.sv]
// top level of the masked paillier pixel cipher
//
//  channel | signals                                         | transfer when
//  --------+-------------------------------------------------+-----------------------
//  input   | in_valid, in_ready, sample_value                | in_valid && in_ready
//  output  | out_valid, out_ready, result_value,             | out_valid && out_ready
//          | was_transformed, frame_last                     |
//  config  | cfg_write_en, cfg_index, cfg_data               | cfg_write_en
//
// one item at a time; a pass-through pixel goes through prep and write to the output register
// an encrypted pixel takes one pass of the shared divider (mod n squared)
// a decrypted pixel takes two divider passes (mod n squared, then / n)
// rst is synchronous and restores the register defaults and clears the position counters
// a stalled output holds the result; a new input is taken once the previous result
// has moved into the output register

module masked_paillier_pixel_cipher #(
  parameter int MAX_SIDE = mpc_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mpc_pkg::SAMPLE_W-1:0]     sample_value,
  // output channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mpc_pkg::SAMPLE_W-1:0]     result_value,
  output logic                             was_transformed,
  output logic                             frame_last,
  // configuration writes
  input  logic                             cfg_write_en,
  input  logic [mpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // configuration registers
  logic [mpc_pkg::MOD_W-1:0]  modulus_n;
  logic                       cipher_mode;
  logic [mpc_pkg::SIDE_W-1:0] frame_width;
  logic [mpc_pkg::SIDE_W-1:0] frame_height;

  mpc_pkg::cmd_t  cmd;
  mpc_pkg::stat_t stat;

  // register writes take effect at once; the user must write only while idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_n    <= mpc_pkg::RST_MODULUS_N;
      cipher_mode  <= mpc_pkg::RST_CIPHER_MODE;
      frame_width  <= mpc_pkg::RST_FRAME_WIDTH;
      frame_height <= mpc_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_write_en) begin
      case (cfg_index)
        mpc_pkg::REG_MODULUS_N:    modulus_n    <= cfg_data[mpc_pkg::MOD_W-1:0];
        mpc_pkg::REG_CIPHER_MODE:  cipher_mode  <= cfg_data[0];
        mpc_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[mpc_pkg::SIDE_W-1:0];
        mpc_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[mpc_pkg::SIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencing: accept, products, divider passes, output write
  mpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // raster position, n squared and m times n, shared divider, output register
  mpc_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .modulus_n       (modulus_n),
    .cipher_mode     (cipher_mode),
    .frame_width     (frame_width),
    .frame_height    (frame_height),
    .sample_value    (sample_value),
    .result_value    (result_value),
    .was_transformed (was_transformed),
    .frame_last      (frame_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready)
  );

endmodule
